>>> rtl/core/disjoint_set_union_find_defines.svh
// Assertion macros used by the port-level checker of the union-find block.
`ifndef DISJOINT_SET_UNION_FIND_DEFINES_SVH
`define DISJOINT_SET_UNION_FIND_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("union-find check failed");

// Next-cycle implication, disabled while reset is high.
`define DSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("union-find check failed");

// Next-cycle implication that is also checked across reset.
`define DSU_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("union-find check failed");

`endif

>>> rtl/core/dsu_pkg.sv
// Package with widths, codes and defaults of the union-find block.
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

  localparam int IDX_W          = 10;
  localparam int RANK_W         = 4;
  localparam int TDATA_W        = 24;
  localparam int NODES_DEFAULT  = 1024;

  localparam logic [RANK_W-1:0] RANK_INIT = 4'd1;
  localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;

  localparam logic OP_UNION = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/dsu_store.sv
// Single-port synchronous memory holding the rank and parent of every element.
`timescale 1ns / 1ps
`default_nettype none

module dsu_store #(
  parameter int AW = 10,
  parameter int DW = dsu_pkg::RANK_W + 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/disjoint_set_union_find.sv
// Top level of the union-find store with union by rank and path compression.
//
//   channel   dir   fields
//   s_*       in    tuser: opcode; tdata: node_a, node_b
//   m_*       out   tuser: result_flag; tdata: root_a, root_b
//
// After reset the store is swept once, one entry per cycle, over all NODES entries;
// s_tready stays low during the sweep. One item at a time, one store access per cycle.
// A union walks each node up to its root and then links the two roots, with a raise
// step more when equal ranks raise a rank; a query has no link step and instead walks
// each path once more, pointing every node on it at the root, the root included.
// A result waits in the output register; the next one waits until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module disjoint_set_union_find #(
  parameter int NODES = dsu_pkg::NODES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // [9:0] node_a, [19:10] node_b, [23:20] zero
  input  wire logic [dsu_pkg::TDATA_W-1:0] s_tdata,
  // [0] opcode
  input  wire logic                        s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [9:0] root_a, [19:10] root_b, [23:20] zero
  output logic      [dsu_pkg::TDATA_W-1:0] m_tdata,
  // [0] result_flag
  output logic                             m_tuser
);

  localparam int AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW  = dsu_pkg::RANK_W + AW;
  localparam int IW  = dsu_pkg::IDX_W;
  localparam int RW  = dsu_pkg::RANK_W;
  localparam int PAD = dsu_pkg::TDATA_W - 2 * IW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_START = 9'b000000100,
    S_FIND  = 9'b000001000,
    S_CRD   = 9'b000010000,
    S_CWR   = 9'b000100000,
    S_LINK  = 9'b001000000,
    S_RAISE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_cnt;
  logic            op;
  logic [IW-1:0]   node_a;
  logic [IW-1:0]   node_b;
  logic            phase;
  logic [AW-1:0]   cur;
  logic [IW-1:0]   root_a;
  logic [IW-1:0]   root_b;
  logic [RW-1:0]   rank_a;
  logic [RW-1:0]   rank_b;
  logic            out_flag;
  logic [IW-1:0]   out_root_a;
  logic [IW-1:0]   out_root_b;

  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [DW-1:0]   mem_wdata;
  logic [DW-1:0]   mem_rdata;

  logic [IW-1:0]   node_sel;
  logic            node_in;
  logic            a_in;
  logic            b_in;
  logic [AW-1:0]   rd_parent;
  logic [RW-1:0]   rd_rank;
  logic            root_hit;
  logic [IW-1:0]   root_cur;
  logic            link_needed;
  logic [RW-1:0]   rank_up;
  logic            out_free;

  dsu_store #(
    .AW(AW),
    .DW(DW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign node_sel    = phase ? node_b : node_a;
  assign node_in     = 32'(node_sel) < NODES;
  assign a_in        = 32'(node_a) < NODES;
  assign b_in        = 32'(node_b) < NODES;
  assign rd_parent   = mem_rdata[AW-1:0];
  assign rd_rank     = mem_rdata[DW-1:AW];
  assign root_hit    = (rd_parent == cur);
  assign root_cur    = phase ? root_b : root_a;
  assign link_needed = (root_a != root_b) && a_in && b_in;
  assign rank_up     = (rank_b == dsu_pkg::RANK_MAX) ? rank_b : rank_b + RW'(1);
  assign out_free    = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{PAD{1'b0}}, out_root_b, out_root_a};
  assign m_tuser  = out_flag;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur;
    mem_wdata = {rank_a, AW'(root_b)};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = {dsu_pkg::RANK_INIT, clr_cnt};
      end
      S_START: begin
        mem_addr = AW'(node_sel);
      end
      S_FIND: begin
        if (!root_hit) begin
          mem_addr = rd_parent;
        end
      end
      S_CWR: begin
        if (!root_hit) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_rank, AW'(root_cur)};
        end
      end
      S_LINK: begin
        if (link_needed) begin
          mem_we = 1'b1;
          if (rank_a > rank_b) begin
            mem_addr  = AW'(root_b);
            mem_wdata = {rank_b, AW'(root_a)};
          end else begin
            mem_addr  = AW'(root_a);
            mem_wdata = {rank_a, AW'(root_b)};
          end
        end
      end
      S_RAISE: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(root_b);
        mem_wdata = {rank_up, AW'(root_b)};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            node_a <= s_tdata[IW-1:0];
            node_b <= s_tdata[2*IW-1:IW];
            phase  <= 1'b0;
            state  <= S_START;
          end
        end
        S_START: begin
          cur <= AW'(node_sel);
          if (node_in) begin
            state <= S_FIND;
          end else begin
            if (phase) begin
              root_b <= node_sel;
              state  <= (op == dsu_pkg::OP_UNION) ? S_LINK : S_OUT;
            end else begin
              root_a <= node_sel;
              phase  <= 1'b1;
              state  <= S_START;
            end
          end
        end
        S_FIND: begin
          if (!root_hit) begin
            cur <= rd_parent;
          end else begin
            if (phase) begin
              root_b <= IW'(cur);
              rank_b <= rd_rank;
            end else begin
              root_a <= IW'(cur);
              rank_a <= rd_rank;
            end
            if (op == dsu_pkg::OP_QUERY) begin
              cur   <= AW'(node_sel);
              state <= S_CRD;
            end else if (phase) begin
              state <= S_LINK;
            end else begin
              phase <= 1'b1;
              state <= S_START;
            end
          end
        end
        S_CRD: begin
          state <= S_CWR;
        end
        S_CWR: begin
          if (!root_hit) begin
            cur   <= rd_parent;
            state <= S_CRD;
          end else if (phase) begin
            state <= S_OUT;
          end else begin
            phase <= 1'b1;
            state <= S_START;
          end
        end
        S_LINK: begin
          if (link_needed && (rank_a == rank_b)) begin
            state <= S_RAISE;
          end else begin
            state <= S_OUT;
          end
        end
        S_RAISE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_flag   <= (op == dsu_pkg::OP_QUERY) ? (root_a == root_b) : link_needed;
            out_root_a <= root_a;
            out_root_b <= root_b;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dsu_checker.sv
// Port-level checker for the union-find block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "disjoint_set_union_find_defines.svh"

module dsu_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [dsu_pkg::TDATA_W-1:0] m_tdata,
  input wire logic                        m_tuser
);

  // The store is swept after reset, so no transfer is taken right away.
  `DSU_ASSERT_ALWAYS_NEXT(a_no_take_after_reset, rst, !s_tready)

  // Items are handled one at a time: an input transfer closes the input side.
  `DSU_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

  // A new result only appears from a cycle in which no input was offered ready.
  `DSU_ASSERT_NOW(a_result_while_busy, $rose(m_tvalid), $past(!s_tready))

  `DSU_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
